/* sv/rwf_pkg.sv */
package rwf_pkg;

   // register defaults
   localparam logic [11:0] FRONT_BLOCK_RESET = 12'd350;
   localparam logic [11:0] WALL_SEEN_RESET   = 12'd500;
   localparam logic [11:0] TARGET_WALL_RESET = 12'd250;
   localparam logic [9:0]  DEADBAND_RESET    = 10'd20;
   localparam logic [15:0] STEER_GAIN_RESET  = 16'd512;
   localparam logic [11:0] MAX_STEER_RESET   = 12'd1000;
   localparam logic [9:0]  CRUISE_RESET      = 10'd200;
   localparam logic [11:0] SPIN_RESET        = 12'd500;

   // register indexes
   localparam logic [2:0] REG_FRONT_BLOCK = 3'd0;
   localparam logic [2:0] REG_WALL_SEEN   = 3'd1;
   localparam logic [2:0] REG_TARGET_WALL = 3'd2;
   localparam logic [2:0] REG_DEADBAND    = 3'd3;
   localparam logic [2:0] REG_STEER_GAIN  = 3'd4;
   localparam logic [2:0] REG_MAX_STEER   = 3'd5;
   localparam logic [2:0] REG_CRUISE      = 3'd6;
   localparam logic [2:0] REG_SPIN        = 3'd7;

   // default tuning for the top level parameters
   localparam int PRE_COMMIT_MM_DEF      = 150;
   localparam int POST_COMMIT_MM_DEF     = 300;
   localparam int QUARTER_TURN_MRAD_DEF  = 1571;
   localparam int ANGLE_TOL_MRAD_DEF     = 50;
   localparam int SLOW_THRESH_MRAD_S_DEF = 300;
   localparam int SLOW_FACTOR_Q8_DEF     = 128;

   // commit distances stay below 2**DIST_W mm
   localparam int DIST_W = 12;

   // mode codes as seen on the result port
   localparam logic [2:0] MODE_DECIDE_CODE  = 3'd0;
   localparam logic [2:0] MODE_FORWARD_CODE = 3'd1;
   localparam logic [2:0] MODE_RIGHT_CODE   = 3'd2;
   localparam logic [2:0] MODE_LEFT_CODE    = 3'd3;
   localparam logic [2:0] MODE_HALF_CODE    = 3'd4;
   localparam logic [2:0] MODE_PRE_CODE     = 3'd5;
   localparam logic [2:0] MODE_POST_CODE    = 3'd6;

   typedef enum logic [6:0] {
      ST_DECIDE  = 7'b0000001,
      ST_FORWARD = 7'b0000010,
      ST_RIGHT   = 7'b0000100,
      ST_LEFT    = 7'b0001000,
      ST_HALF    = 7'b0010000,
      ST_PRE     = 7'b0100000,
      ST_POST    = 7'b1000000
   } rwf_mode_type;

   typedef struct packed {
      logic [11:0] front_block_mm;
      logic [11:0] wall_seen_mm;
      logic [11:0] target_wall_mm;
      logic [9:0]  deadband_mm;
      logic [15:0] steer_gain_q8;
      logic [11:0] max_steer_mrad_s;
      logic [9:0]  cruise_mm_s;
      logic [11:0] spin_mrad_s;
   } rwf_cfg_type;

   // forward-driving command worked out from the right range
   typedef struct packed {
      logic               wall_r;
      logic [9:0]         speed;
      logic signed [12:0] rate;
   } rwf_steer_type;

   // decoded item held between the two register stages
   typedef struct packed {
      logic               path_open;
      logic               wall_l;
      logic               quarter_hit;
      logic               half_hit;
      rwf_steer_type      steer;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
   } rwf_item_type;

endpackage

/* sv/rwf_steer.sv */
module rwf_steer #(
   parameter int SLOW_THRESH_MRAD_S = rwf_pkg::SLOW_THRESH_MRAD_S_DEF,
   parameter int SLOW_FACTOR_Q8     = rwf_pkg::SLOW_FACTOR_Q8_DEF
) (
   input  rwf_pkg::rwf_cfg_type   cfg,
   input  logic [13:0]            right_range,
   output rwf_pkg::rwf_steer_type steer
);
   import rwf_pkg::*;

   localparam logic [11:0] SLOW_THRESH = 12'(SLOW_THRESH_MRAD_S);
   localparam logic [8:0]  SLOW_FACTOR = 9'(SLOW_FACTOR_Q8);

   logic               wall_r;
   logic signed [14:0] err;
   logic [14:0]        err_abs_full;
   logic [13:0]        err_abs;
   logic               err_pos;
   logic               steer_on;
   logic [29:0]        gain_prod;
   logic [30:0]        gain_round;
   logic [22:0]        mag_raw;
   logic [11:0]        mag;
   logic [12:0]        mag_neg;
   logic [18:0]        slow_prod;
   logic               slow;

   // signed distance error against the target
   assign wall_r       = right_range < {2'b00, cfg.wall_seen_mm};
   assign err          = $signed({1'b0, right_range}) - $signed({3'b000, cfg.target_wall_mm});
   assign err_abs_full = err[14] ? 15'(-err) : 15'(err);
   assign err_abs      = err_abs_full[13:0];
   assign err_pos      = !err[14] && (err != 15'sd0);
   assign steer_on     = wall_r && (err_abs > {4'b0000, cfg.deadband_mm});

   // proportional term, rounded, then saturated
   assign gain_prod  = {14'd0, cfg.steer_gain_q8} * {16'd0, err_abs};
   assign gain_round = {1'b0, gain_prod} + 31'd128;
   assign mag_raw    = gain_round[30:8];
   assign mag        = (mag_raw > {11'd0, cfg.max_steer_mrad_s}) ?
                       cfg.max_steer_mrad_s : mag_raw[11:0];
   assign mag_neg    = 13'(-{1'b0, mag});
   assign slow       = mag > SLOW_THRESH;

   // reduced speed for large corrections
   assign slow_prod = {9'd0, cfg.cruise_mm_s} * {10'd0, SLOW_FACTOR};

   always_comb begin
      steer.wall_r = wall_r;
      steer.speed  = cfg.cruise_mm_s;
      steer.rate   = 13'sd0;
      if (steer_on) begin
         steer.rate = err_pos ? $signed(mag_neg) : $signed({1'b0, mag});
         if (slow) begin
            steer.speed = slow_prod[17:8];
         end
      end
   end

endmodule

/* sv/right_wall_follower_controller.sv */
// Right-wall-following controller: takes one sensor item (ranges, position, angle turned)
// per clock and returns one command item (speed, turn rate, mode after the step) for it.
// An accepted item is decoded and its steering product formed in front of the stage
// register; from the stage register the mode update and the squared commit distance are
// worked out and loaded into the result register, from which the result is offered.
// Sustained rate is one item per clock, limited only by the result side taking items;
// while a finished result waits the stage register can still take one more item, after
// which the input stalls. The user must write registers through the csr port only
// while no item is in flight; the block itself does not enforce this.
module right_wall_follower_controller #(
   parameter int PRE_COMMIT_MM      = rwf_pkg::PRE_COMMIT_MM_DEF,
   parameter int POST_COMMIT_MM     = rwf_pkg::POST_COMMIT_MM_DEF,
   parameter int QUARTER_TURN_MRAD  = rwf_pkg::QUARTER_TURN_MRAD_DEF,
   parameter int ANGLE_TOL_MRAD     = rwf_pkg::ANGLE_TOL_MRAD_DEF,
   parameter int SLOW_THRESH_MRAD_S = rwf_pkg::SLOW_THRESH_MRAD_S_DEF,
   parameter int SLOW_FACTOR_Q8     = rwf_pkg::SLOW_FACTOR_Q8_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [13:0]        req_front_range,
   input  logic [13:0]        req_left_range,
   input  logic [13:0]        req_right_range,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [12:0] req_angle_turned,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_linear_speed,
   output logic signed [12:0] rsp_turn_rate,
   output logic [2:0]         rsp_mode_now
);
   import rwf_pkg::*;

   localparam int          QUARTER_DONE = QUARTER_TURN_MRAD - ANGLE_TOL_MRAD;
   localparam int          HALF_DONE    = 2 * QUARTER_TURN_MRAD - ANGLE_TOL_MRAD;
   localparam bit          QUARTER_NEG  = (QUARTER_DONE <= 0);
   localparam bit          HALF_NEG     = (HALF_DONE <= 0);
   localparam logic [12:0] QUARTER_LIM  = 13'(QUARTER_DONE);
   localparam logic [12:0] HALF_LIM     = 13'(HALF_DONE);
   localparam logic [2*DIST_W-1:0] PRE_SQ  = (2*DIST_W)'(PRE_COMMIT_MM * PRE_COMMIT_MM);
   localparam logic [2*DIST_W-1:0] POST_SQ = (2*DIST_W)'(POST_COMMIT_MM * POST_COMMIT_MM);

   rwf_cfg_type        cfg_ff;
   rwf_cfg_type        cfg_in;
   rwf_steer_type      steer;
   rwf_item_type       item_in;
   rwf_item_type       item_ff;
   logic               in_valid_ff;
   logic               in_valid_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               accept;
   logic               advance;
   rwf_mode_type       mode_ff;
   rwf_mode_type       mode_in;
   logic signed [15:0] start_x_ff;
   logic signed [15:0] start_x_in;
   logic signed [15:0] start_y_ff;
   logic signed [15:0] start_y_in;
   logic [9:0]         speed_ff;
   logic [9:0]         speed_in;
   logic signed [12:0] rate_ff;
   logic signed [12:0] rate_in;
   logic [2:0]         code_ff;
   logic [2:0]         code_in;
   logic [13:0]        ang_neg;
   logic [12:0]        ang_abs;
   logic signed [16:0] dx;
   logic signed [16:0] dy;
   logic [16:0]        dx_abs;
   logic [16:0]        dy_abs;
   logic [2*DIST_W-1:0] dx_sq;
   logic [2*DIST_W-1:0] dy_sq;
   logic [2*DIST_W:0]   dist_sq;
   logic               far;
   logic               pre_reached;
   logic               post_reached;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_FRONT_BLOCK: cfg_in.front_block_mm   = csr_wdata[11:0];
            REG_WALL_SEEN:   cfg_in.wall_seen_mm     = csr_wdata[11:0];
            REG_TARGET_WALL: cfg_in.target_wall_mm   = csr_wdata[11:0];
            REG_DEADBAND:    cfg_in.deadband_mm      = csr_wdata[9:0];
            REG_STEER_GAIN:  cfg_in.steer_gain_q8    = csr_wdata;
            REG_MAX_STEER:   cfg_in.max_steer_mrad_s = csr_wdata[11:0];
            REG_CRUISE:      cfg_in.cruise_mm_s      = csr_wdata[9:0];
            REG_SPIN:        cfg_in.spin_mrad_s      = csr_wdata[11:0];
            default: begin
            end
         endcase
      end
   end

   // handshake between the stage register and the result register
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign accept       = req_valid && req_ready;
   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   rwf_steer #(
      .SLOW_THRESH_MRAD_S(SLOW_THRESH_MRAD_S),
      .SLOW_FACTOR_Q8    (SLOW_FACTOR_Q8)
   ) u_steer (
      .cfg        (cfg_ff),
      .right_range(req_right_range),
      .steer      (steer)
   );

   // decode of the incoming item
   assign ang_neg = 14'(-{req_angle_turned[12], req_angle_turned});
   assign ang_abs = req_angle_turned[12] ? ang_neg[12:0] : req_angle_turned;

   always_comb begin
      item_in.path_open   = req_front_range > {2'b00, cfg_ff.front_block_mm};
      item_in.wall_l      = req_left_range < {2'b00, cfg_ff.wall_seen_mm};
      item_in.quarter_hit = QUARTER_NEG || (ang_abs >= QUARTER_LIM);
      item_in.half_hit    = HALF_NEG || (ang_abs >= HALF_LIM);
      item_in.steer       = steer;
      item_in.pos_x       = req_pos_x;
      item_in.pos_y       = req_pos_y;
   end

   // squared distance from the commit start point
   assign dx     = {item_ff.pos_x[15], item_ff.pos_x} - {start_x_ff[15], start_x_ff};
   assign dy     = {item_ff.pos_y[15], item_ff.pos_y} - {start_y_ff[15], start_y_ff};
   assign dx_abs = dx[16] ? 17'(-dx) : 17'(dx);
   assign dy_abs = dy[16] ? 17'(-dy) : 17'(dy);
   assign far    = (|dx_abs[16:DIST_W]) || (|dy_abs[16:DIST_W]);
   assign dx_sq  = dx_abs[DIST_W-1:0] * dx_abs[DIST_W-1:0];
   assign dy_sq  = dy_abs[DIST_W-1:0] * dy_abs[DIST_W-1:0];
   assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
   assign pre_reached  = far || (dist_sq >= {1'b0, PRE_SQ});
   assign post_reached = far || (dist_sq >= {1'b0, POST_SQ});

   // mode update and command for the staged item
   always_comb begin
      mode_in    = mode_ff;
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      speed_in   = 10'd0;
      rate_in    = 13'sd0;
      case (mode_ff)
         ST_DECIDE: begin
            if (item_ff.wall_l && !item_ff.steer.wall_r) begin
               mode_in = ST_HALF;
            end else if (!item_ff.steer.wall_r) begin
               start_x_in = item_ff.pos_x;
               start_y_in = item_ff.pos_y;
               mode_in    = ST_PRE;
            end else if (!item_ff.path_open) begin
               mode_in = ST_LEFT;
            end else begin
               mode_in = ST_FORWARD;
            end
         end
         ST_FORWARD: begin
            speed_in = item_ff.steer.speed;
            rate_in  = item_ff.steer.rate;
            if (!item_ff.path_open || !item_ff.steer.wall_r) begin
               mode_in = ST_DECIDE;
            end
         end
         ST_RIGHT: begin
            if (item_ff.quarter_hit) begin
               start_x_in = item_ff.pos_x;
               start_y_in = item_ff.pos_y;
               mode_in    = ST_POST;
            end else begin
               rate_in = $signed(13'(-{1'b0, cfg_ff.spin_mrad_s}));
            end
         end
         ST_LEFT: begin
            if (item_ff.quarter_hit) begin
               mode_in = ST_DECIDE;
            end else begin
               rate_in = $signed({1'b0, cfg_ff.spin_mrad_s});
            end
         end
         ST_HALF: begin
            if (item_ff.half_hit) begin
               mode_in = ST_FORWARD;
            end else begin
               rate_in = $signed({1'b0, cfg_ff.spin_mrad_s});
            end
         end
         ST_PRE: begin
            if (pre_reached) begin
               mode_in = ST_RIGHT;
            end else begin
               speed_in = cfg_ff.cruise_mm_s;
            end
         end
         ST_POST: begin
            if (post_reached) begin
               mode_in = ST_DECIDE;
            end else begin
               speed_in = cfg_ff.cruise_mm_s;
            end
         end
         default: begin
            mode_in = ST_DECIDE;
         end
      endcase
   end

   // mode code for the result
   always_comb begin
      case (mode_in)
         ST_DECIDE:  code_in = MODE_DECIDE_CODE;
         ST_FORWARD: code_in = MODE_FORWARD_CODE;
         ST_RIGHT:   code_in = MODE_RIGHT_CODE;
         ST_LEFT:    code_in = MODE_LEFT_CODE;
         ST_HALF:    code_in = MODE_HALF_CODE;
         ST_PRE:     code_in = MODE_PRE_CODE;
         ST_POST:    code_in = MODE_POST_CODE;
         default:    code_in = MODE_DECIDE_CODE;
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.front_block_mm   <= FRONT_BLOCK_RESET;
         cfg_ff.wall_seen_mm     <= WALL_SEEN_RESET;
         cfg_ff.target_wall_mm   <= TARGET_WALL_RESET;
         cfg_ff.deadband_mm      <= DEADBAND_RESET;
         cfg_ff.steer_gain_q8    <= STEER_GAIN_RESET;
         cfg_ff.max_steer_mrad_s <= MAX_STEER_RESET;
         cfg_ff.cruise_mm_s      <= CRUISE_RESET;
         cfg_ff.spin_mrad_s      <= SPIN_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= ST_FORWARD;
         start_x_ff   <= 16'sd0;
         start_y_ff   <= 16'sd0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff    <= mode_in;
            start_x_ff <= start_x_in;
            start_y_ff <= start_y_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      if (advance) begin
         speed_ff <= speed_in;
         rate_ff  <= rate_in;
         code_ff  <= code_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_linear_speed = speed_ff;
   assign rsp_turn_rate    = rate_ff;
   assign rsp_mode_now     = code_ff;

`ifndef SYNTH
   // a staged item that cannot move on stays staged
   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("staged item dropped");

   // commanded speed never exceeds cruise
   a_speed_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_linear_speed <= cfg_ff.cruise_mm_s)
      else $error("speed above cruise");

   // in-place turns do not drive forward
   a_turn_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode_now == MODE_RIGHT_CODE || rsp_mode_now == MODE_LEFT_CODE ||
                    rsp_mode_now == MODE_HALF_CODE) |-> rsp_linear_speed == 10'd0)
      else $error("speed during in-place turn");

   // pre-turn commit drives straight
   a_pre_straight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode_now == MODE_PRE_CODE |-> rsp_turn_rate == 13'sd0)
      else $error("turn rate during pre-turn commit");
`endif

endmodule
